### rtl/assert_macros.svh
// Assertion macros shared by the receiver modules.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true at a sampled edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/abdr_pkg.sv
// Shared constants, codes and the queue entry type of the datagram receiver.
// Used by every module of the receiver; depends on nothing.
package abdr_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int DATA_ZERO_LEN = 256;
  localparam int HDR_LEN = 4;
  localparam int POS_W = 9;
  localparam int LEN_W = 9;
  localparam int SUM_W = 16;
  localparam int TOTAL_W = 32;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [SUM_W-1:0] SUM_GOOD = 16'hFFFF;

  localparam logic [7:0] FL_HS_REQ = 8'd2;
  localparam logic [7:0] FL_HS_DONE = 8'd18;
  localparam logic [7:0] FL_CLOSE = 8'd17;
  localparam logic [7:0] FL_DATA_ACK = 8'd16;
  localparam logic [7:0] FL_NAME_OK = 8'd80;
  localparam logic [7:0] FL_NAME_BAD = 8'd208;
  localparam logic [7:0] FL_FIN_LAST = 8'd1;
  localparam logic [7:0] FL_DATA_SEQ0 = 8'd0;
  localparam logic [7:0] FL_DATA_SEQ1 = 8'd128;
  localparam logic [7:0] FL_DONE_MASK = 8'h50;

  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_NAME_BIT = 6;
  localparam int FLAG_SEQ_BIT = 7;

  localparam logic [3:0] EV_IGNORED = 4'd0;
  localparam logic [3:0] EV_HS_REQ = 4'd1;
  localparam logic [3:0] EV_HS_DONE = 4'd2;
  localparam logic [3:0] EV_NAME_OK = 4'd3;
  localparam logic [3:0] EV_NAME_BAD = 4'd4;
  localparam logic [3:0] EV_DATA_OK = 4'd5;
  localparam logic [3:0] EV_DATA_NO_TARGET = 4'd6;
  localparam logic [3:0] EV_SEQ_MISMATCH = 4'd7;
  localparam logic [3:0] EV_CSUM_BAD = 4'd8;
  localparam logic [3:0] EV_XFER_DONE = 4'd9;
  localparam logic [3:0] EV_FINISH = 4'd10;
  localparam logic [3:0] EV_CLOSE_OK = 4'd11;

  localparam logic [1:0] PH_OPEN = 2'd0;
  localparam logic [1:0] PH_CLOSING = 2'd1;
  localparam logic [1:0] PH_CLOSED = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic             has_pay;
    logic             has_verd;
    logic [7:0]       data;
    logic [7:0]       flags;
    logic             good;
    logic [LEN_W-1:0] len;
  } abdr_entry_t;

endpackage

### rtl/alternating_bit_datagram_receiver_core.sv
// Top level of the alternating-bit datagram receiver.
// Depends on abdr_pkg, abdr_front, abdr_queue and abdr_back.
//
// One datagram byte is accepted per cycle while the four-entry queue between the
// front and back parts has room; first (s_tuser) restarts framing. Each byte
// gives zero, one or two output words: payload bytes give a tentative word
// (m_tuser 0) and the closing byte of a frame also gives the verdict word
// (m_tuser 1). The back part sends one word per cycle from its output register
// while m_tready is high, so a payload byte that closes a frame sends its two
// words one after the other; all other bytes keep up at one per cycle. A word
// is held in a queue slot and then in the output register before it leaves.
module alternating_bit_datagram_receiver_core import abdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] payload_byte, [8] payload_is_name, [12:9] event_res, [13] accept_payload,
  // [15:14] reply_count, [23:16] reply_flags_first, [31:24] reply_flags_second,
  // [63:32] byte_total
  output logic [63:0] m_tdata,
  output logic        m_tuser    // [0] kind
);

  abdr_entry_t entry;
  abdr_entry_t head;
  logic        push;
  logic        pop;
  logic        empty;
  logic        full;

  abdr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .full     (full),
    .push     (push),
    .entry    (entry)
  );

  abdr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  abdr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/abdr_queue.sv
// Short queue of classified bytes between the front and back parts.
// Depends on abdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abdr_queue import abdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  abdr_entry_t entry,
  input  logic        pop,
  output abdr_entry_t head,
  output logic        empty,
  output logic        full
);

  abdr_entry_t        slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  `ASSERT_NEVER(a_push_when_full, push && full, "queue written while full")
  `ASSERT_NEVER(a_pop_when_empty, pop && empty, "queue read while empty")
  `ASSERT_HOLDS(a_head_useful, !empty |-> (head.has_pay || head.has_verd), "empty entry queued")

endmodule

### rtl/abdr_front.sv
// Front part: accepts datagram bytes, tracks framing and checksum, classifies each byte.
// Depends on abdr_pkg; feeds abdr_queue.
module abdr_front import abdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first
  input  logic        full,
  output logic        push,
  output abdr_entry_t entry
);

  logic [POS_W-1:0] byte_position;
  logic             in_frame;
  logic [7:0]       header_flags;
  logic [LEN_W-1:0] payload_length;
  logic [SUM_W-1:0] running_sum;

  logic             accept;
  logic             in_fr;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] pos_next;
  logic [SUM_W-1:0] sum_cur;
  logic [SUM_W-1:0] addend;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_next;
  logic [7:0]       flags_next;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_clamp;
  logic [LEN_W-1:0] len_next;
  logic             frame_end;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    in_fr      = s_tuser | in_frame;
    pos_cur    = s_tuser ? '0 : byte_position;
    sum_cur    = s_tuser ? '0 : running_sum;
    addend     = (pos_cur == '0) ? {s_tdata, 8'h00} : {8'h00, s_tdata};
    sum_wide   = {1'b0, sum_cur} + {1'b0, addend};
    sum_next   = sum_wide[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, sum_wide[SUM_W]};
    flags_next = (pos_cur == POS_W'(2)) ? s_tdata : header_flags;
    if (s_tdata == 8'd0 && (flags_next == FL_DATA_SEQ0 || flags_next == FL_DATA_SEQ1)) begin
      len_raw = LEN_W'(DATA_ZERO_LEN);
    end else begin
      len_raw = {{(LEN_W-8){1'b0}}, s_tdata};
    end
    len_clamp = (len_raw > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : len_raw;
    len_next  = (pos_cur == POS_W'(3)) ? len_clamp : payload_length;
    pos_next  = pos_cur + 1'b1;
    frame_end = (pos_next >= POS_W'(HDR_LEN)) &&
                (pos_next == POS_W'(HDR_LEN) + POS_W'(len_next));
    push      = accept && in_fr && ((pos_cur >= POS_W'(HDR_LEN)) || frame_end);

    entry.has_pay  = (pos_cur >= POS_W'(HDR_LEN));
    entry.has_verd = frame_end;
    entry.data     = s_tdata;
    entry.flags    = flags_next;
    entry.good     = (sum_next == SUM_GOOD);
    entry.len      = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      in_frame       <= 1'b0;
      header_flags   <= '0;
      payload_length <= '0;
      running_sum    <= '0;
    end else if (accept && in_fr) begin
      byte_position  <= pos_next;
      in_frame       <= !frame_end;
      header_flags   <= flags_next;
      payload_length <= len_next;
      running_sum    <= sum_next;
    end
  end

endmodule

### rtl/abdr_back.sv
// Back part: protocol state, verdicts and the output word register.
// Depends on abdr_pkg and assert_macros.svh; drains abdr_queue.
`include "assert_macros.svh"

module abdr_back import abdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  abdr_entry_t head,
  input  logic        empty,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] payload_byte, [8] payload_is_name, [12:9] event_res, [13] accept_payload,
  // [15:14] reply_count, [23:16] reply_flags_first, [31:24] reply_flags_second,
  // [63:32] byte_total
  output logic [63:0] m_tdata,
  output logic        m_tuser    // [0] kind
);

  logic               expected_seq;
  logic               name_known;
  logic [TOTAL_W-1:0] accepted_total;
  logic [1:0]         link_phase;
  logic               half;

  logic               expected_seq_next;
  logic               name_known_next;
  logic [TOTAL_W-1:0] accepted_total_next;
  logic [1:0]         link_phase_next;

  logic [3:0]         ev;
  logic               acc;
  logic [1:0]         rc;
  logic [7:0]         r1;
  logic [7:0]         r2;
  logic               seq;
  logic               load;
  logic               emit_pay;

  always_comb begin
    ev                  = EV_IGNORED;
    acc                 = 1'b0;
    rc                  = 2'd0;
    r1                  = 8'd0;
    r2                  = 8'd0;
    seq                 = head.flags[FLAG_SEQ_BIT];
    expected_seq_next   = expected_seq;
    name_known_next     = name_known;
    accepted_total_next = accepted_total;
    link_phase_next     = link_phase;
    case (link_phase)
      PH_OPEN: begin
        if (head.flags == FL_HS_DONE) begin
          ev = EV_HS_DONE;
        end else if (head.flags == FL_HS_REQ) begin
          ev = EV_HS_REQ;
          rc = 2'd1;
          r1 = FL_HS_DONE;
        end else if ((head.flags & FL_DONE_MASK) == FL_DONE_MASK) begin
          ev = EV_XFER_DONE;
        end else if (head.flags[FLAG_NAME_BIT]) begin
          rc = 2'd1;
          if (head.good) begin
            ev                  = EV_NAME_OK;
            acc                 = 1'b1;
            r1                  = FL_NAME_OK;
            name_known_next     = 1'b1;
            accepted_total_next = '0;
          end else begin
            ev = EV_NAME_BAD;
            r1 = FL_NAME_BAD;
          end
        end else if (head.flags[FLAG_FIN_BIT]) begin
          ev              = EV_FINISH;
          rc              = 2'd2;
          r1              = FL_CLOSE;
          r2              = FL_FIN_LAST;
          link_phase_next = PH_CLOSING;
        end else begin
          rc = 2'd1;
          if (seq != expected_seq) begin
            ev = EV_SEQ_MISMATCH;
            r1 = FL_DATA_ACK | {~seq, 7'd0};
          end else if (!head.good) begin
            ev = EV_CSUM_BAD;
            r1 = FL_DATA_ACK | {~seq, 7'd0};
          end else begin
            expected_seq_next   = ~expected_seq;
            accepted_total_next = accepted_total + TOTAL_W'(head.len);
            r1                  = FL_DATA_ACK | {seq, 7'd0};
            if (name_known) begin
              ev  = EV_DATA_OK;
              acc = 1'b1;
            end else begin
              ev = EV_DATA_NO_TARGET;
            end
          end
        end
      end
      PH_CLOSING: begin
        ev              = (head.flags == FL_CLOSE) ? EV_CLOSE_OK : EV_IGNORED;
        link_phase_next = PH_CLOSED;
      end
      default: begin
        ev = EV_IGNORED;
      end
    endcase
  end

  assign load     = !empty && (!m_tvalid || m_tready);
  assign emit_pay = head.has_pay && !half;
  assign pop      = load && !(emit_pay && head.has_verd);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid       <= 1'b0;
      half           <= 1'b0;
      expected_seq   <= 1'b0;
      name_known     <= 1'b0;
      accepted_total <= '0;
      link_phase     <= PH_OPEN;
    end else if (load) begin
      m_tvalid <= 1'b1;
      if (emit_pay) begin
        half <= head.has_verd;
      end else begin
        half           <= 1'b0;
        expected_seq   <= expected_seq_next;
        name_known     <= name_known_next;
        accepted_total <= accepted_total_next;
        link_phase     <= link_phase_next;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_pay) begin
        m_tuser <= KIND_PAYLOAD;
        m_tdata <= {accepted_total, 8'd0, 8'd0, 2'd0, 1'b0, EV_IGNORED,
                    head.flags[FLAG_NAME_BIT], head.data};
      end else begin
        m_tuser <= KIND_VERDICT;
        m_tdata <= {accepted_total_next, r2, r1, rc, acc, ev,
                    head.flags[FLAG_NAME_BIT], 8'd0};
      end
    end
  end

  `ASSERT_HOLDS(a_half_pair,
    half |-> (!empty && head.has_pay && head.has_verd),
    "split entry lost")
  `ASSERT_HOLDS(a_commit_event,
    (m_tvalid && m_tdata[13]) |->
      (m_tuser && (m_tdata[12:9] == EV_NAME_OK || m_tdata[12:9] == EV_DATA_OK)),
    "commit on wrong event")
  `ASSERT_HOLDS(a_word_held,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
    "output word changed while stalled")

endmodule

### sim/tb.sv
// Self-checking bench for alternating_bit_datagram_receiver_core: directed frames,
// then random datagram streams with sender and receiver stalls, checked word by word.
// Depends on abdr_pkg and the receiver RTL.
module tb;
  import abdr_pkg::*;

  localparam int NO_EV = -1;
  localparam int STALL_CYCLES = 300;
  localparam int PHASE_BYTES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] FL_NAME = 8'h40;
  localparam logic [7:0] FL_FIN = 8'h01;

  typedef enum logic [1:0] {PAY_RANDOM, PAY_ZERO, PAY_ONES} pay_fill_e;

  typedef struct packed {
    logic       stray;
    logic [7:0] flags;
    logic [7:0] len;
    pay_fill_e  fill;
    logic       good;
    logic       chop;
    int         ev;
  } frame_row_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pay;
    logic        is_name;
    logic [3:0]  ev;
    logic        acc;
    logic [1:0]  rc;
    logic [7:0]  r1;
    logic [7:0]  r2;
    logic [31:0] total;
  } out_word_t;

  localparam frame_row_t DIRECTED [17] = '{
    '{1'b1, 8'h00, 8'd0, PAY_RANDOM, 1'b1, 1'b0, NO_EV},
    '{1'b0, FL_HS_REQ, 8'd0, PAY_ZERO, 1'b1, 1'b0, int'(EV_HS_REQ)},
    '{1'b0, FL_HS_DONE, 8'd0, PAY_ZERO, 1'b1, 1'b0, int'(EV_HS_DONE)},
    '{1'b0, FL_DATA_SEQ0, 8'd3, PAY_RANDOM, 1'b1, 1'b0, int'(EV_DATA_NO_TARGET)},
    '{1'b0, FL_DATA_SEQ0, 8'd2, PAY_RANDOM, 1'b1, 1'b0, int'(EV_SEQ_MISMATCH)},
    '{1'b0, FL_NAME, 8'd4, PAY_RANDOM, 1'b0, 1'b0, int'(EV_NAME_BAD)},
    '{1'b0, FL_NAME, 8'd6, PAY_RANDOM, 1'b1, 1'b0, int'(EV_NAME_OK)},
    '{1'b0, FL_DATA_SEQ1, 8'd1, PAY_RANDOM, 1'b0, 1'b0, int'(EV_CSUM_BAD)},
    '{1'b0, FL_DATA_SEQ1, 8'd0, PAY_ONES, 1'b1, 1'b0, int'(EV_DATA_OK)},
    '{1'b0, FL_DATA_SEQ0, 8'd5, PAY_RANDOM, 1'b1, 1'b1, NO_EV},
    '{1'b0, FL_DATA_SEQ0, 8'd255, PAY_ZERO, 1'b1, 1'b0, int'(EV_DATA_OK)},
    '{1'b0, FL_DONE_MASK, 8'd2, PAY_RANDOM, 1'b1, 1'b0, int'(EV_XFER_DONE)},
    '{1'b0, 8'hFF, 8'd1, PAY_ONES, 1'b0, 1'b0, int'(EV_XFER_DONE)},
    '{1'b0, 8'hC0, 8'd1, PAY_RANDOM, 1'b1, 1'b0, int'(EV_NAME_OK)},
    '{1'b0, 8'h84, 8'd0, PAY_ZERO, 1'b1, 1'b0, int'(EV_DATA_OK)},
    '{1'b1, 8'h00, 8'd0, PAY_RANDOM, 1'b1, 1'b0, NO_EV},
    '{1'b0, FL_HS_REQ, 8'd3, PAY_RANDOM, 1'b0, 1'b0, int'(EV_HS_REQ)}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;

  int          s_tag;
  int          src_idle = 37;
  int          sink_idle = 70;
  logic        stall_req = 1'b0;
  int          bytes_sent = 0;
  int          mismatches = 0;
  int          cycles = 0;
  logic        next_seq = 1'b0;
  logic        left_open = 1'b0;

  logic [8:0]  fr_pos = '0;
  logic        fr_open = 1'b0;
  logic [7:0]  fr_flags = '0;
  logic [8:0]  fr_len = '0;
  logic [15:0] fr_sum = '0;
  logic        want_seq = 1'b0;
  logic        have_name = 1'b0;
  logic [31:0] total_bytes = '0;
  logic [1:0]  link = PH_OPEN;

  out_word_t   pending_words [$];

  alternating_bit_datagram_receiver_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic receive_byte(input logic [7:0] b, input logic first, input int tag);
    out_word_t  w;
    logic       good;
    logic       seqb;
    if (first) begin
      fr_open = 1'b1;
      fr_pos = '0;
      fr_sum = '0;
    end
    if (!fr_open) return;
    fr_sum = fold_add(fr_sum, (fr_pos == 9'd0) ? {b, 8'h00} : {8'h00, b});
    if (fr_pos == 9'd2) fr_flags = b;
    if (fr_pos == 9'd3) begin
      fr_len = {1'b0, b};
      if (b == 8'd0 && (fr_flags == FL_DATA_SEQ0 || fr_flags == FL_DATA_SEQ1))
        fr_len = 9'(DATA_ZERO_LEN);
      if (fr_len > 9'(MAX_PAYLOAD)) fr_len = 9'(MAX_PAYLOAD);
    end
    w = '0;
    w.is_name = fr_flags[FLAG_NAME_BIT];
    if (fr_pos >= 9'(HDR_LEN)) begin
      w.kind = KIND_PAYLOAD;
      w.pay = b;
      w.total = total_bytes;
      pending_words.push_back(w);
    end
    fr_pos = fr_pos + 9'd1;
    if (fr_pos < 9'(HDR_LEN) || fr_pos != 9'(HDR_LEN) + fr_len) return;

    fr_open = 1'b0;
    good = (fr_sum == SUM_GOOD);
    w = '0;
    w.kind = KIND_VERDICT;
    w.is_name = fr_flags[FLAG_NAME_BIT];
    w.ev = EV_IGNORED;
    if (link == PH_CLOSING) begin
      w.ev = (fr_flags == FL_CLOSE) ? EV_CLOSE_OK : EV_IGNORED;
      link = PH_CLOSED;
    end else if (link != PH_OPEN) begin
      w.ev = EV_IGNORED;
    end else if (fr_flags == FL_HS_DONE) begin
      w.ev = EV_HS_DONE;
    end else if (fr_flags == FL_HS_REQ) begin
      w.ev = EV_HS_REQ;
      w.rc = 2'd1;
      w.r1 = FL_HS_DONE;
    end else if ((fr_flags & FL_DONE_MASK) == FL_DONE_MASK) begin
      w.ev = EV_XFER_DONE;
    end else if (fr_flags[FLAG_NAME_BIT]) begin
      w.rc = 2'd1;
      if (good) begin
        w.ev = EV_NAME_OK;
        w.acc = 1'b1;
        w.r1 = FL_NAME_OK;
        have_name = 1'b1;
        total_bytes = '0;
      end else begin
        w.ev = EV_NAME_BAD;
        w.r1 = FL_NAME_BAD;
      end
    end else if (fr_flags[FLAG_FIN_BIT]) begin
      w.ev = EV_FINISH;
      w.rc = 2'd2;
      w.r1 = FL_CLOSE;
      w.r2 = FL_FIN_LAST;
      link = PH_CLOSING;
    end else begin
      seqb = fr_flags[FLAG_SEQ_BIT];
      w.rc = 2'd1;
      w.r1 = FL_DATA_ACK | {~seqb, 7'd0};
      if (seqb != want_seq) begin
        w.ev = EV_SEQ_MISMATCH;
      end else if (!good) begin
        w.ev = EV_CSUM_BAD;
      end else begin
        want_seq = ~want_seq;
        total_bytes = total_bytes + {23'd0, fr_len};
        w.r1 = FL_DATA_ACK | {seqb, 7'd0};
        w.ev = have_name ? EV_DATA_OK : EV_DATA_NO_TARGET;
        w.acc = have_name;
      end
    end
    w.total = total_bytes;
    if (tag != NO_EV && int'(w.ev) != tag) begin
      $error("event_res of planned frame: expected %0d, predicted %0d", tag, w.ev);
      mismatches++;
    end
    pending_words.push_back(w);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) receive_byte(s_tdata, s_tuser, s_tag);
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          $error("word with nothing pending: tuser %0b tdata %h", m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          got.kind = m_tuser;
          got.pay = m_tdata[7:0];
          got.is_name = m_tdata[8];
          got.ev = m_tdata[12:9];
          got.acc = m_tdata[13];
          got.rc = m_tdata[15:14];
          got.r1 = m_tdata[23:16];
          got.r2 = m_tdata[31:24];
          got.total = m_tdata[63:32];
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("payload_byte", 32'(want.pay), 32'(got.pay));
          check_field("payload_is_name", 32'(want.is_name), 32'(got.is_name));
          check_field("event_res", 32'(want.ev), 32'(got.ev));
          check_field("accept_payload", 32'(want.acc), 32'(got.acc));
          check_field("reply_count", 32'(want.rc), 32'(got.rc));
          check_field("reply_flags_first", 32'(want.r1), 32'(got.r1));
          check_field("reply_flags_second", 32'(want.r2), 32'(got.r2));
          check_field("byte_total", want.total, got.total);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL alternating_bit_datagram_receiver_core");
      $finish;
    end
  end

  // receiver side: random back-pressure, plus one long hold on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic first, input int tag);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= first;
    s_tag <= tag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] flags, input logic [7:0] len,
                            input pay_fill_e fill, input logic good, input logic chop,
                            input int ev);
    logic [7:0]  frame [$];
    logic [15:0] sum;
    logic [15:0] csum;
    int          n;
    int          stop;
    n = (len == 8'd0 && (flags == FL_DATA_SEQ0 || flags == FL_DATA_SEQ1)) ?
        DATA_ZERO_LEN : int'(len);
    frame = '{flags, len};
    for (int i = 0; i < n; i++) begin
      case (fill)
        PAY_ZERO: frame.push_back(8'h00);
        PAY_ONES: frame.push_back(8'hFF);
        default:  frame.push_back(8'($urandom));
      endcase
    end
    sum = 16'h0000;
    foreach (frame[i]) sum = fold_add(sum, {8'h00, frame[i]});
    csum = ~sum;
    if (!good) csum = csum ^ (16'h0001 << $urandom_range(15));
    frame.push_front(csum[7:0]);
    frame.push_front(csum[15:8]);
    stop = chop ? int'($urandom_range(frame.size() - 1, 1)) : frame.size();
    for (int i = 0; i < stop; i++)
      send_word(frame[i], i == 0, (i == stop - 1) ? ev : NO_EV);
    left_open = chop;
  endtask

  // mostly well-formed traffic in sequence, with broken frames and noise mixed in
  task automatic send_random_frame();
    int         pick;
    int         r;
    logic [7:0] flags;
    logic [7:0] len;
    logic       good;
    logic       chop;
    pick = $urandom_range(99);
    r = $urandom_range(199);
    if (r < 170) len = 8'($urandom_range(8, 1));
    else if (r < 196) len = 8'($urandom_range(40));
    else len = 8'($urandom_range(255, 200));
    good = 1'b1;
    chop = 1'b0;
    flags = {next_seq, 7'd0};
    if ($urandom_range(3) == 0) flags = flags | (8'($urandom) & 8'h3C);
    if (pick < 45) begin
      send_frame(flags, len, PAY_RANDOM, 1'b1, 1'b0, NO_EV);
      next_seq = ~next_seq;
      return;
    end
    if (pick < 53) begin
      flags[FLAG_SEQ_BIT] = ~next_seq;
    end else if (pick < 61) begin
      good = 1'b0;
    end else if (pick < 71) begin
      flags = FL_NAME | (8'($urandom) & 8'h8F);
      good = ($urandom_range(3) != 0);
    end else if (pick < 77) begin
      flags = $urandom_range(1) ? FL_HS_REQ : FL_HS_DONE;
      good = 1'($urandom_range(1));
    end else if (pick < 80) begin
      flags = FL_DONE_MASK | (8'($urandom) & 8'hAF);
      good = 1'($urandom_range(1));
    end else if (pick < 92) begin
      flags = 8'($urandom);
      if (!flags[FLAG_NAME_BIT]) flags[FLAG_FIN_BIT] = 1'b0;
      good = 1'b0;
    end else if (pick < 97) begin
      flags = 8'($urandom);
      chop = 1'b1;
    end else begin
      if (!left_open) send_word(8'($urandom), 1'b0, NO_EV);
      return;
    end
    send_frame(flags, len, PAY_RANDOM, good, chop, NO_EV);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_words.size() != 0);
  endtask

  initial begin
    int   stop_at;
    logic close_ok;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    s_tag <= NO_EV;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].stray)
        send_word(8'($urandom), 1'b0, DIRECTED[i].ev);
      else
        send_frame(DIRECTED[i].flags, DIRECTED[i].len, DIRECTED[i].fill, DIRECTED[i].good,
                   DIRECTED[i].chop, DIRECTED[i].ev);
    end
    hold_until_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle = 37; sink_idle = 70; end
        1: begin src_idle = 70; sink_idle = 37; end
        default: begin
          src_idle = 0;
          sink_idle = 0;
          stall_req = 1'b1;
        end
      endcase
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) send_random_frame();
      hold_until_drained();
    end

    // close the link last: nothing after it is acted on
    send_frame(FL_FIN, 8'd2, PAY_RANDOM, 1'b0, 1'b0, int'(EV_FINISH));
    close_ok = 1'($urandom_range(1));
    send_frame(close_ok ? FL_CLOSE : FL_HS_REQ, 8'd1, PAY_RANDOM, 1'b1, 1'b0,
               close_ok ? int'(EV_CLOSE_OK) : int'(EV_IGNORED));
    repeat (6) send_random_frame();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS alternating_bit_datagram_receiver_core");
    else
      $display("FAIL alternating_bit_datagram_receiver_core");
    $finish;
  end

endmodule
